// ===== src/ocean_spectrum_time_update_unit_macros.svh =====
// assertion macros shared by the ocean spectrum time update rtl
`ifndef OCEAN_SPECTRUM_TIME_UPDATE_UNIT_MACROS_SVH
`define OCEAN_SPECTRUM_TIME_UPDATE_UNIT_MACROS_SVH

// same-cycle implication on clock, disabled in reset
`define OSTU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, disabled in reset
`define OSTU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ostu_pkg.sv =====
// types, constants and helpers of the ocean spectrum time update unit
package ostu_pkg;

   // grid geometry
   localparam int GRID_SIZE = 64;
   localparam int HALF_GRID = GRID_SIZE / 2;
   localparam int SPAN      = GRID_SIZE + 1;
   localparam int DEPTH     = SPAN * SPAN;
   localparam int ADDR_W    = $clog2(DEPTH);

   // field widths
   localparam int IDX_W      = 7;
   localparam int SCALE_W    = 24;
   localparam int TIME_W     = 32;
   localparam int AMP_W      = 24;
   localparam int ENTRY_W    = 2 * AMP_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int OUT_W      = 24;

   // register reset values
   localparam logic [SCALE_W-1:0] KX_SCALE_RST = 24'd65536;
   localparam logic [SCALE_W-1:0] KZ_SCALE_RST = 24'd65536;
   localparam logic [SCALE_W-1:0] GRAVITY_RST  = 24'd642908;

   // datapath widths
   localparam int KX_W     = 30;   // |index| times scale
   localparam int RAD_W    = 61;   // kx^2 + kz^2
   localparam int ROOT1_W  = 31;   // |k|
   localparam int GK_W     = 55;   // gravity * |k|
   localparam int ROOT2_W  = 28;   // omega
   localparam int PH_W     = 60;   // omega * t
   localparam int MOD_STEPS = 25;
   localparam int PHASE_W  = 35;
   localparam int ANG_W    = 35;
   localparam int CORDIC_STEPS = 30;
   localparam int CX_W     = 34;
   localparam int CS_W     = 32;
   localparam int SUM_W    = AMP_W + 1;
   localparam int PROD_W   = SUM_W + CS_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int RND_SHIFT = 30;

   // phase constants
   localparam logic [PHASE_W-1:0] TWO_PI_Q32 = 35'd26986075409;
   localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [CX_W-1:0]  CORDIC_GAIN = 34'sd652032874;

   // saturation limits
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd8388607);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd8388608);

   // pipeline stage positions
   localparam int ST_A   = 0;
   localparam int ST_B   = 1;
   localparam int ST_C   = 2;
   localparam int ST_D   = 3;
   localparam int ST_SQ1 = 4;
   localparam int ST_G   = ST_SQ1 + ROOT1_W;
   localparam int ST_SQ2 = ST_G + 1;
   localparam int ST_P   = ST_SQ2 + ROOT2_W;
   localparam int ST_MOD = ST_P + 1;
   localparam int ST_F   = ST_MOD + MOD_STEPS;
   localparam int ST_CR  = ST_F + 1;
   localparam int ST_M   = ST_CR + CORDIC_STEPS;
   localparam int ST_S   = ST_M + 1;
   localparam int ST_R   = ST_S + 1;
   localparam int NSTAGE = ST_R + 1;

   // item kinds
   typedef enum logic {
      MODE_LOAD    = 1'b0,
      MODE_COMPUTE = 1'b1
   } mode_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KX_SCALE = 2'd0,
      CSR_KZ_SCALE = 2'd1,
      CSR_GRAVITY  = 2'd2
   } csr_index_type;

   // per-item data that rides along the pipeline
   typedef struct packed {
      logic                     center;
      logic [TIME_W-1:0]        time_now;
      logic signed [SUM_W-1:0]  sum_ad;
      logic signed [SUM_W-1:0]  sum_be;
      logic signed [SUM_W-1:0]  dif_ad;
      logic signed [SUM_W-1:0]  dif_be;
   } side_type;

   // index pair lies on the grid
   function automatic logic in_grid(input int a, input int b);
      return (a >= -HALF_GRID) && (a <= HALF_GRID) && (b >= -HALF_GRID) && (b <= HALF_GRID);
   endfunction

   // table slot of an index pair
   function automatic logic [ADDR_W-1:0] slot_of(input int a, input int b);
      return ADDR_W'(SPAN * (a + HALF_GRID) + (b + HALF_GRID));
   endfunction

   // cordic angle step in q30
   function automatic logic signed [ANG_W-1:0] cordic_atan(input int k);
      logic signed [ANG_W-1:0] r;
      case (k)
         0:       r = 35'sd843314857;
         1:       r = 35'sd497837829;
         2:       r = 35'sd263043837;
         3:       r = 35'sd133525159;
         4:       r = 35'sd67021687;
         5:       r = 35'sd33543516;
         6:       r = 35'sd16775851;
         7:       r = 35'sd8388437;
         8:       r = 35'sd4194283;
         9:       r = 35'sd2097149;
         10:      r = 35'sd1048576;
         default: r = ANG_W'(64'sd1 <<< (30 - k));
      endcase
      return r;
   endfunction

endpackage

// ===== src/ostu_ifs.sv =====
// request and response channel interfaces of the ocean spectrum time update unit
interface ostu_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   mode;
   logic signed [ostu_pkg::IDX_W-1:0]      row_index;
   logic signed [ostu_pkg::IDX_W-1:0]      col_index;
   logic [ostu_pkg::TIME_W-1:0]            time_now;
   logic signed [ostu_pkg::AMP_W-1:0]      amp_real;
   logic signed [ostu_pkg::AMP_W-1:0]      amp_imag;

   modport source (output valid, mode, row_index, col_index, time_now, amp_real, amp_imag,
                   input ready);
   modport sink (input valid, mode, row_index, col_index, time_now, amp_real, amp_imag,
                 output ready);
endinterface

interface ostu_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ostu_pkg::OUT_W-1:0]      height_real;
   logic signed [ostu_pkg::OUT_W-1:0]      height_imag;

   modport source (output valid, height_real, height_imag, input ready);
   modport sink (input valid, height_real, height_imag, output ready);
endinterface

// ===== src/ostu_ram.sv =====
// generic single-write, single-read ram with registered read data
module ostu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/ocean_spectrum_time_update_unit.sv =====
// Ocean spectrum time update unit. Holds the initial amplitude table h0(i,j) in two
// mirrored copies of a (GRID_SIZE+1)^2 x 48 ram, so the entries at (i,j) and (-i,-j)
// are read in the same cycle. A load word writes one entry at acceptance and gives no
// response; a compute word returns h0(i,j)e^{iwt} + conj(h0(-i,-j))e^{-iwt}. The block
// takes one word per cycle while the pipeline advances; a compute word passes through
// the bit-serial pipelines of two square roots (31 and 28 stages), the 25-stage phase
// reduction and the 30-stage cordic before the response register. The whole pipeline
// advances while the response register is empty or being taken. The table needs no
// clearing pass; an entry read before it is written gives an arbitrary result.
`include "ocean_spectrum_time_update_unit_macros.svh"

module ocean_spectrum_time_update_unit (
   input  logic                              clock,
   input  logic                              reset,
   ostu_req_if.sink                          req_chan,
   ostu_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [ostu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ostu_pkg::CSR_DATA_W-1:0]   csr_data
);
   localparam int NS = ostu_pkg::NSTAGE;

   // configuration registers
   logic [ostu_pkg::SCALE_W-1:0] kx_scale_ff;
   logic [ostu_pkg::SCALE_W-1:0] kz_scale_ff;
   logic [ostu_pkg::SCALE_W-1:0] gravity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kx_scale_ff <= ostu_pkg::KX_SCALE_RST;
         kz_scale_ff <= ostu_pkg::KZ_SCALE_RST;
         gravity_ff  <= ostu_pkg::GRAVITY_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            ostu_pkg::CSR_KX_SCALE: kx_scale_ff <= csr_data;
            ostu_pkg::CSR_KZ_SCALE: kz_scale_ff <= csr_data;
            ostu_pkg::CSR_GRAVITY:  gravity_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NS-1:0] vld_ff;
   logic          adv;
   logic          acc_in;
   logic          is_compute;

   assign adv        = !vld_ff[ostu_pkg::ST_R] || rsp_chan.ready;
   assign acc_in     = req_chan.valid && adv;
   assign is_compute = (req_chan.mode == ostu_pkg::MODE_COMPUTE);
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], acc_in && is_compute};
      end
   end

   // index decode and table access
   int row_i;
   int col_i;
   logic ok_pos;
   logic ok_neg;
   logic [ostu_pkg::ADDR_W-1:0] addr_pos;
   logic [ostu_pkg::ADDR_W-1:0] addr_neg;
   logic [ostu_pkg::ENTRY_W-1:0] entry_wr;
   logic [ostu_pkg::ENTRY_W-1:0] entry_pos;
   logic [ostu_pkg::ENTRY_W-1:0] entry_neg;
   logic wr_en;

   always_comb begin
      row_i    = int'(req_chan.row_index);
      col_i    = int'(req_chan.col_index);
      ok_pos   = ostu_pkg::in_grid(row_i, col_i);
      ok_neg   = ostu_pkg::in_grid(-row_i, -col_i);
      addr_pos = ostu_pkg::slot_of(row_i, col_i);
      addr_neg = ostu_pkg::slot_of(-row_i, -col_i);
      entry_wr = {req_chan.amp_real, req_chan.amp_imag};
      wr_en    = acc_in && !is_compute && ok_pos;
   end

   ostu_ram #(.WIDTH(ostu_pkg::ENTRY_W), .DEPTH(ostu_pkg::DEPTH)) u_ram_pos (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_pos),
      .wr_data (entry_wr),
      .rd_en   (adv),
      .rd_addr (addr_pos),
      .rd_data (entry_pos)
   );

   ostu_ram #(.WIDTH(ostu_pkg::ENTRY_W), .DEPTH(ostu_pkg::DEPTH)) u_ram_neg (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_pos),
      .wr_data (entry_wr),
      .rd_en   (adv),
      .rd_addr (addr_neg),
      .rd_data (entry_neg)
   );

   // stage a: index magnitudes and range flags
   logic [ostu_pkg::IDX_W-1:0] abs_i_ff;
   logic [ostu_pkg::IDX_W-1:0] abs_j_ff;
   logic                       ok_pos_ff;
   logic                       ok_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         abs_i_ff  <= ostu_pkg::IDX_W'((row_i < 0) ? -row_i : row_i);
         abs_j_ff  <= ostu_pkg::IDX_W'((col_i < 0) ? -col_i : col_i);
         ok_pos_ff <= ok_pos;
         ok_neg_ff <= ok_neg;
      end
   end

   // side data pipeline
   ostu_pkg::side_type side_ff [NS];
   ostu_pkg::side_type side_a_in;
   ostu_pkg::side_type side_b_in;
   logic signed [ostu_pkg::AMP_W-1:0] amp_a;
   logic signed [ostu_pkg::AMP_W-1:0] amp_b;
   logic signed [ostu_pkg::AMP_W-1:0] amp_d;
   logic signed [ostu_pkg::AMP_W-1:0] amp_e;

   always_comb begin
      side_a_in          = '0;
      side_a_in.center   = (row_i == 0) && (col_i == 0);
      side_a_in.time_now = req_chan.time_now;
      amp_a = ok_pos_ff ? entry_pos[ostu_pkg::ENTRY_W-1:ostu_pkg::AMP_W] : '0;
      amp_b = ok_pos_ff ? entry_pos[ostu_pkg::AMP_W-1:0] : '0;
      amp_d = ok_neg_ff ? entry_neg[ostu_pkg::ENTRY_W-1:ostu_pkg::AMP_W] : '0;
      amp_e = ok_neg_ff ? entry_neg[ostu_pkg::AMP_W-1:0] : '0;
      side_b_in        = side_ff[ostu_pkg::ST_A];
      side_b_in.sum_ad = ostu_pkg::SUM_W'(amp_a) + ostu_pkg::SUM_W'(amp_d);
      side_b_in.sum_be = ostu_pkg::SUM_W'(amp_b) + ostu_pkg::SUM_W'(amp_e);
      side_b_in.dif_ad = ostu_pkg::SUM_W'(amp_a) - ostu_pkg::SUM_W'(amp_d);
      side_b_in.dif_be = ostu_pkg::SUM_W'(amp_b) - ostu_pkg::SUM_W'(amp_e);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[ostu_pkg::ST_A] <= side_a_in;
         side_ff[ostu_pkg::ST_B] <= side_b_in;
         for (int k = ostu_pkg::ST_C; k < NS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // stages b to d: wave vector and its squared length
   logic [ostu_pkg::KX_W-1:0]    kx_ff;
   logic [ostu_pkg::KX_W-1:0]    kz_ff;
   logic [2*ostu_pkg::KX_W-1:0]  kxx_ff;
   logic [2*ostu_pkg::KX_W-1:0]  kzz_ff;
   logic [ostu_pkg::RAD_W-1:0]   rad_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kx_ff  <= ostu_pkg::KX_W'(abs_i_ff * kx_scale_ff);
         kz_ff  <= ostu_pkg::KX_W'(abs_j_ff * kz_scale_ff);
         kxx_ff <= kx_ff * kx_ff;
         kzz_ff <= kz_ff * kz_ff;
         rad_ff <= ostu_pkg::RAD_W'(kxx_ff) + ostu_pkg::RAD_W'(kzz_ff);
      end
   end

   // first square root, one result bit per stage
   logic [ostu_pkg::RAD_W-1:0]   rem1_ff  [ostu_pkg::ROOT1_W];
   logic [ostu_pkg::ROOT1_W-1:0] root1_ff [ostu_pkg::ROOT1_W];

   for (genvar n = 0; n < ostu_pkg::ROOT1_W; n++) begin : g_sqrt1
      localparam int B = ostu_pkg::ROOT1_W - 1 - n;
      logic [ostu_pkg::RAD_W-1:0]   rem_prev;
      logic [ostu_pkg::ROOT1_W-1:0] root_prev;
      logic [ostu_pkg::RAD_W:0]     delta;
      logic [ostu_pkg::RAD_W-1:0]   rem1_in;
      logic [ostu_pkg::ROOT1_W-1:0] root1_in;

      always_comb begin
         if (n == 0) begin
            rem_prev  = rad_ff;
            root_prev = '0;
         end else begin
            rem_prev  = rem1_ff[(n == 0) ? 0 : n-1];
            root_prev = root1_ff[(n == 0) ? 0 : n-1];
         end
         delta = ((ostu_pkg::RAD_W+1)'(root_prev) << (B + 1))
               | ((ostu_pkg::RAD_W+1)'(1) << (2 * B));
         if ({1'b0, rem_prev} >= delta) begin
            rem1_in  = rem_prev - ostu_pkg::RAD_W'(delta);
            root1_in = root_prev | (ostu_pkg::ROOT1_W'(1) << B);
         end else begin
            rem1_in  = rem_prev;
            root1_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem1_ff[n]  <= rem1_in;
            root1_ff[n] <= root1_in;
         end
      end
   end

   // stage g: gravity times wave number
   logic [ostu_pkg::GK_W-1:0] gk_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         gk_ff <= ostu_pkg::GK_W'(gravity_ff * root1_ff[ostu_pkg::ROOT1_W-1]);
      end
   end

   // second square root gives omega
   logic [ostu_pkg::GK_W-1:0]    rem2_ff  [ostu_pkg::ROOT2_W];
   logic [ostu_pkg::ROOT2_W-1:0] root2_ff [ostu_pkg::ROOT2_W];

   for (genvar n = 0; n < ostu_pkg::ROOT2_W; n++) begin : g_sqrt2
      localparam int B = ostu_pkg::ROOT2_W - 1 - n;
      logic [ostu_pkg::GK_W-1:0]    rem_prev;
      logic [ostu_pkg::ROOT2_W-1:0] root_prev;
      logic [ostu_pkg::GK_W:0]      delta;
      logic [ostu_pkg::GK_W-1:0]    rem2_in;
      logic [ostu_pkg::ROOT2_W-1:0] root2_in;

      always_comb begin
         if (n == 0) begin
            rem_prev  = gk_ff;
            root_prev = '0;
         end else begin
            rem_prev  = rem2_ff[(n == 0) ? 0 : n-1];
            root_prev = root2_ff[(n == 0) ? 0 : n-1];
         end
         delta = ((ostu_pkg::GK_W+1)'(root_prev) << (B + 1))
               | ((ostu_pkg::GK_W+1)'(1) << (2 * B));
         if ({1'b0, rem_prev} >= delta) begin
            rem2_in  = rem_prev - ostu_pkg::GK_W'(delta);
            root2_in = root_prev | (ostu_pkg::ROOT2_W'(1) << B);
         end else begin
            rem2_in  = rem_prev;
            root2_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem2_ff[n]  <= rem2_in;
            root2_ff[n] <= root2_in;
         end
      end
   end

   // stage p: phase = omega * t in q32
   logic [ostu_pkg::PH_W-1:0] ph_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff <= ostu_pkg::PH_W'(root2_ff[ostu_pkg::ROOT2_W-1]
                                  * side_ff[ostu_pkg::ST_P-1].time_now);
      end
   end

   // phase reduction modulo two pi, one shifted subtract per stage
   logic [ostu_pkg::PH_W-1:0] md_ff [ostu_pkg::MOD_STEPS];

   for (genvar n = 0; n < ostu_pkg::MOD_STEPS; n++) begin : g_mod
      localparam int K = ostu_pkg::MOD_STEPS - 1 - n;
      localparam logic [ostu_pkg::PH_W-1:0] SUB =
         ostu_pkg::PH_W'(ostu_pkg::TWO_PI_Q32) << K;
      logic [ostu_pkg::PH_W-1:0] md_prev;
      logic [ostu_pkg::PH_W-1:0] md_in;

      always_comb begin
         md_prev = (n == 0) ? ph_ff : md_ff[(n == 0) ? 0 : n-1];
         md_in   = (md_prev >= SUB) ? md_prev - SUB : md_prev;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            md_ff[n] <= md_in;
         end
      end
   end

   // stage f: q30 angle folded into plus or minus half pi
   logic signed [ostu_pkg::ANG_W-1:0] ang_ff;
   logic                              flip_ff;
   logic signed [ostu_pkg::ANG_W-1:0] ang0;
   logic signed [ostu_pkg::ANG_W-1:0] ang1;
   logic signed [ostu_pkg::ANG_W-1:0] ang_in;
   logic                              flip_in;

   always_comb begin
      ang0 = $signed({2'b00, md_ff[ostu_pkg::MOD_STEPS-1][ostu_pkg::PHASE_W-1:2]});
      ang1 = (ang0 > ostu_pkg::PI_Q30) ? ang0 - ostu_pkg::TWO_PI_Q30 : ang0;
      if (ang1 > ostu_pkg::HALF_PI_Q30) begin
         ang_in  = ang1 - ostu_pkg::PI_Q30;
         flip_in = 1'b1;
      end else if (ang1 < -ostu_pkg::HALF_PI_Q30) begin
         ang_in  = ang1 + ostu_pkg::PI_Q30;
         flip_in = 1'b1;
      end else begin
         ang_in  = ang1;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff  <= ang_in;
         flip_ff <= flip_in;
      end
   end

   // cordic rotation, one micro-rotation per stage
   logic signed [ostu_pkg::CX_W-1:0]  cx_ff [ostu_pkg::CORDIC_STEPS];
   logic signed [ostu_pkg::CX_W-1:0]  cy_ff [ostu_pkg::CORDIC_STEPS];
   logic signed [ostu_pkg::ANG_W-1:0] cz_ff [ostu_pkg::CORDIC_STEPS];
   logic                              cf_ff [ostu_pkg::CORDIC_STEPS];

   for (genvar k = 0; k < ostu_pkg::CORDIC_STEPS; k++) begin : g_cordic
      localparam logic signed [ostu_pkg::ANG_W-1:0] ATAN = ostu_pkg::cordic_atan(k);
      logic signed [ostu_pkg::CX_W-1:0]  x_prev;
      logic signed [ostu_pkg::CX_W-1:0]  y_prev;
      logic signed [ostu_pkg::ANG_W-1:0] z_prev;
      logic                              f_prev;
      logic signed [ostu_pkg::CX_W-1:0]  cx_in;
      logic signed [ostu_pkg::CX_W-1:0]  cy_in;
      logic signed [ostu_pkg::ANG_W-1:0] cz_in;

      always_comb begin
         if (k == 0) begin
            x_prev = ostu_pkg::CORDIC_GAIN;
            y_prev = '0;
            z_prev = ang_ff;
            f_prev = flip_ff;
         end else begin
            x_prev = cx_ff[(k == 0) ? 0 : k-1];
            y_prev = cy_ff[(k == 0) ? 0 : k-1];
            z_prev = cz_ff[(k == 0) ? 0 : k-1];
            f_prev = cf_ff[(k == 0) ? 0 : k-1];
         end
         if (z_prev >= 0) begin
            cx_in = x_prev - (y_prev >>> k);
            cy_in = y_prev + (x_prev >>> k);
            cz_in = z_prev - ATAN;
         end else begin
            cx_in = x_prev + (y_prev >>> k);
            cy_in = y_prev - (x_prev >>> k);
            cz_in = z_prev + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[k] <= cx_in;
            cy_ff[k] <= cy_in;
            cz_ff[k] <= cz_in;
            cf_ff[k] <= f_prev;
         end
      end
   end

   // stage m: amplitude sums times cosine and sine
   logic signed [ostu_pkg::CX_W-1:0]   cx_last;
   logic signed [ostu_pkg::CX_W-1:0]   cy_last;
   logic signed [ostu_pkg::CS_W-1:0]   cos_v;
   logic signed [ostu_pkg::CS_W-1:0]   sin_v;
   logic signed [ostu_pkg::PROD_W-1:0] p0_ff;
   logic signed [ostu_pkg::PROD_W-1:0] p1_ff;
   logic signed [ostu_pkg::PROD_W-1:0] p2_ff;
   logic signed [ostu_pkg::PROD_W-1:0] p3_ff;
   ostu_pkg::side_type                 side_m;

   always_comb begin
      cx_last = cf_ff[ostu_pkg::CORDIC_STEPS-1] ? -cx_ff[ostu_pkg::CORDIC_STEPS-1]
                                                 : cx_ff[ostu_pkg::CORDIC_STEPS-1];
      cy_last = cf_ff[ostu_pkg::CORDIC_STEPS-1] ? -cy_ff[ostu_pkg::CORDIC_STEPS-1]
                                                 : cy_ff[ostu_pkg::CORDIC_STEPS-1];
      cos_v   = ostu_pkg::CS_W'(cx_last);
      sin_v   = ostu_pkg::CS_W'(cy_last);
      side_m  = side_ff[ostu_pkg::ST_M-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff <= side_m.sum_ad * cos_v;
         p1_ff <= side_m.sum_be * sin_v;
         p2_ff <= side_m.dif_ad * sin_v;
         p3_ff <= side_m.dif_be * cos_v;
      end
   end

   // stage s: real and imaginary accumulations
   logic signed [ostu_pkg::ACC_W-1:0] re_ff;
   logic signed [ostu_pkg::ACC_W-1:0] im_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff <= ostu_pkg::ACC_W'(p0_ff) - ostu_pkg::ACC_W'(p1_ff);
         im_ff <= ostu_pkg::ACC_W'(p2_ff) + ostu_pkg::ACC_W'(p3_ff);
      end
   end

   // stage r: round, saturate, response register
   logic signed [ostu_pkg::ACC_W-1:0] re_rnd;
   logic signed [ostu_pkg::ACC_W-1:0] im_rnd;
   logic signed [ostu_pkg::OUT_W-1:0] hr_in;
   logic signed [ostu_pkg::OUT_W-1:0] hi_in;
   logic signed [ostu_pkg::OUT_W-1:0] hr_ff;
   logic signed [ostu_pkg::OUT_W-1:0] hi_ff;

   always_comb begin
      re_rnd = (re_ff + (ostu_pkg::ACC_W'(1) << (ostu_pkg::RND_SHIFT - 1)))
               >>> ostu_pkg::RND_SHIFT;
      im_rnd = (im_ff + (ostu_pkg::ACC_W'(1) << (ostu_pkg::RND_SHIFT - 1)))
               >>> ostu_pkg::RND_SHIFT;
      if (re_rnd > ostu_pkg::SAT_MAX) begin
         hr_in = ostu_pkg::OUT_W'(ostu_pkg::SAT_MAX);
      end else if (re_rnd < ostu_pkg::SAT_MIN) begin
         hr_in = ostu_pkg::OUT_W'(ostu_pkg::SAT_MIN);
      end else begin
         hr_in = ostu_pkg::OUT_W'(re_rnd);
      end
      if (im_rnd > ostu_pkg::SAT_MAX) begin
         hi_in = ostu_pkg::OUT_W'(ostu_pkg::SAT_MAX);
      end else if (im_rnd < ostu_pkg::SAT_MIN) begin
         hi_in = ostu_pkg::OUT_W'(ostu_pkg::SAT_MIN);
      end else begin
         hi_in = ostu_pkg::OUT_W'(im_rnd);
      end
      // the center coefficient is always zero
      if (side_ff[ostu_pkg::ST_R-1].center) begin
         hr_in = '0;
         hi_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hr_ff <= hr_in;
         hi_ff <= hi_in;
      end
   end

   assign rsp_chan.valid       = vld_ff[ostu_pkg::ST_R];
   assign rsp_chan.height_real = hr_ff;
   assign rsp_chan.height_imag = hi_ff;

   // checks
   `OSTU_ASSERT_NEXT(a_load_no_word, acc_in && !is_compute, !vld_ff[ostu_pkg::ST_A], "load word entered the compute pipeline")
   `OSTU_ASSERT_NOW(a_phase_reduced, vld_ff[ostu_pkg::ST_F-1], md_ff[ostu_pkg::MOD_STEPS-1] < ostu_pkg::PH_W'(ostu_pkg::TWO_PI_Q32), "phase not reduced below two pi")
   `OSTU_ASSERT_NOW(a_angle_folded, vld_ff[ostu_pkg::ST_F], (ang_ff <= ostu_pkg::HALF_PI_Q30) && (ang_ff >= -ostu_pkg::HALF_PI_Q30), "cordic angle outside half pi")
   `OSTU_ASSERT_NOW(a_center_zero, rsp_chan.valid && side_ff[ostu_pkg::ST_R].center, (hr_ff == '0) && (hi_ff == '0), "center coefficient not zero")
endmodule
